[src/bts_pkg.sv]
package bts_pkg;

  // Width of the thread fields on the ports.
  localparam int unsigned FIELD_W = 16;

  typedef enum logic [1:0] {
    FN_SCHEDULE = 2'd0,
    FN_IN_ORDER = 2'd1,
    FN_NEXT     = 2'd2,
    FN_RESTART  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  // Control broadcast from the scheduler to every stack cell.
  typedef struct packed {
    cell_op_t op;
    logic     shift;
  } cell_ctrl_t;

endpackage

[src/bts_cell.sv]
// One stack entry. Cell 0 is the top of the stack; deeper cells sit at
// higher indexes.
module bts_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 7,
  parameter int unsigned W   = 16
) (
  input  logic                clk,
  input  bts_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       point,
  input  logic [W-1:0]        new_id,
  input  logic [W-1:0]        from_prev,
  input  logic [W-1:0]        from_next,
  output logic [W-1:0]        data
);

  logic [W-1:0] data_next;
  logic [CW:0]  my_idx;
  logic [CW:0]  pt;

  assign my_idx = (CW + 1)'(IDX);
  assign pt     = {1'b0, point};

  always_comb begin
    data_next = data;
    if (ctrl.shift) begin
      unique case (ctrl.op)
        bts_pkg::OP_INSERT: begin
          // Cells above the insert point hold; below it, move one deeper.
          if (my_idx > pt) begin
            data_next = from_prev;
          end else if (my_idx == pt) begin
            data_next = new_id;
          end
        end
        bts_pkg::OP_POP: data_next = from_next;
        default:         data_next = data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[src/backtrack_thread_scheduler.sv]
// Depth-first thread scheduler. Takes one request (schedule, schedule in
// order, take next, restart) per clock while in_ready is high, and returns
// one result beat per request, registered when the request is accepted; a
// new request is taken in the same cycle the previous result is taken. The
// stack is a row of STACK_DEPTH cells with the top in cell 0: push, insert
// and pop move every affected cell one place at once, so a request's cost
// does not depend on stack depth or insert position. A push or insert into
// a full stack is dropped and flagged on overflow. Stack contents are not
// cleared at reset; only entries below the current length are ever read.
module backtrack_thread_scheduler #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [bts_pkg::FIELD_W-1:0] thread_id,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [bts_pkg::FIELD_W-1:0] out_thread,
  output logic                        out_valid,
  output logic                        pending,
  output logic                        overflow
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 2);

  logic                active_valid, active_valid_next;
  logic [ID_WIDTH-1:0] active_thread, active_thread_next;
  logic [CW-1:0]       length, length_next;
  logic [CW-1:0]       insert_index, insert_index_next;

  logic [ID_WIDTH-1:0] cell_q [STACK_DEPTH];
  bts_pkg::cell_ctrl_t ctrl;
  logic [CW-1:0]       point;

  logic                in_fire;
  logic                full;
  logic [31:0]         tid_ext;
  logic [ID_WIDTH-1:0] id;
  logic [ID_WIDTH-1:0] given;
  logic [31:0]         given_ext;
  logic                given_valid;
  logic                dropped;

  assign in_ready  = !res_valid || res_ready;
  assign in_fire   = in_valid && in_ready;
  assign full      = (length == CW'(STACK_DEPTH));
  assign tid_ext   = 32'(thread_id);
  assign id        = tid_ext[ID_WIDTH-1:0];
  assign given_ext = 32'(given);

  always_comb begin
    active_valid_next  = active_valid;
    active_thread_next = active_thread;
    length_next        = length;
    insert_index_next  = insert_index;
    ctrl.op            = bts_pkg::OP_HOLD;
    ctrl.shift         = 1'b0;
    point              = '0;
    given              = '0;
    given_valid        = 1'b0;
    dropped            = 1'b0;
    if (in_fire) begin
      unique case (bts_pkg::func_t'(func))
        bts_pkg::FN_SCHEDULE, bts_pkg::FN_IN_ORDER: begin
          if (bts_pkg::func_t'(func) == bts_pkg::FN_SCHEDULE || insert_index > length) begin
            // Plain schedule; in-order variant parks the index at the old length.
            insert_index_next = (bts_pkg::func_t'(func) == bts_pkg::FN_SCHEDULE) ?
                                CW'(length + 1'b1) : length;
            if (!active_valid) begin
              active_valid_next  = 1'b1;
              active_thread_next = id;
            end else if (full) begin
              dropped = 1'b1;
            end else begin
              ctrl.op     = bts_pkg::OP_INSERT;
              ctrl.shift  = 1'b1;
              length_next = CW'(length + 1'b1);
            end
          end else if (full) begin
            dropped = 1'b1;
          end else begin
            // Insert point counted from the top; zero is a plain push.
            ctrl.op     = bts_pkg::OP_INSERT;
            ctrl.shift  = 1'b1;
            point       = CW'(length - insert_index);
            length_next = CW'(length + 1'b1);
          end
        end
        bts_pkg::FN_NEXT: begin
          insert_index_next = CW'(length + 1'b1);
          if (active_valid) begin
            given              = active_thread;
            given_valid        = 1'b1;
            active_valid_next  = 1'b0;
            active_thread_next = '0;
          end else if (length != '0) begin
            given       = cell_q[0];
            given_valid = 1'b1;
            ctrl.op     = bts_pkg::OP_POP;
            ctrl.shift  = 1'b1;
            length_next = CW'(length - 1'b1);
          end
        end
        bts_pkg::FN_RESTART: begin
          active_valid_next  = 1'b0;
          active_thread_next = '0;
          insert_index_next  = '0;
        end
        default: ;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      logic [ID_WIDTH-1:0] prev_d;
      logic [ID_WIDTH-1:0] next_d;
      if (gi == 0) begin : g_first
        assign prev_d = id;
      end else begin : g_mid_prev
        assign prev_d = cell_q[gi-1];
      end
      if (gi == STACK_DEPTH - 1) begin : g_last
        assign next_d = '0;
      end else begin : g_mid_next
        assign next_d = cell_q[gi+1];
      end
      bts_cell #(
        .IDX (gi),
        .CW  (CW),
        .W   (ID_WIDTH)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .point     (point),
        .new_id    (id),
        .from_prev (prev_d),
        .from_next (next_d),
        .data      (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      active_valid  <= 1'b0;
      active_thread <= '0;
      length        <= '0;
      insert_index  <= '0;
      res_valid     <= 1'b0;
    end else begin
      active_valid  <= active_valid_next;
      active_thread <= active_thread_next;
      length        <= length_next;
      insert_index  <= insert_index_next;
      if (in_fire) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result beat payload; held while the beat waits.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_thread <= given_ext[bts_pkg::FIELD_W-1:0];
      out_valid  <= given_valid;
      pending    <= active_valid_next || (length_next != '0);
      overflow   <= dropped;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= CW'(STACK_DEPTH))
    else $error("stack length beyond depth");

  // Take next sets the index before its pop, so it may sit two above the length.
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(insert_index) <= (CW+1)'(length) + (CW+1)'(2))
    else $error("insert index beyond length plus two");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && func == bts_pkg::FN_RESTART |=> !active_valid && insert_index == '0)
    else $error("restart left active slot or index set");

  a_give_no_drop: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> !overflow)
    else $error("thread handed out and drop flagged together");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    in_fire && ctrl.op == bts_pkg::OP_POP |=> length == CW'($past(length) - 1'b1))
    else $error("pop did not shorten the stack");

endmodule
